@@ sv/dit_pkg.sv @@
// Package for the dual interval timer with status flags.
// Holds the word types, register addresses, codes and timer constants.
// Used by dit_core and dual_interval_timer_with_status.
package dit_pkg;

    localparam int unsigned CNT_A_W = 10;
    localparam int unsigned CNT_B_W = 8;
    localparam int unsigned PRE_W   = 4;

    localparam logic [CNT_A_W-1:0] A_FULL = 10'd1023;
    localparam logic [CNT_B_W-1:0] B_FULL = 8'd255;

    localparam logic [7:0] ADDR_RELOAD_A_HI = 8'h24;
    localparam logic [7:0] ADDR_RELOAD_A_LO = 8'h25;
    localparam logic [7:0] ADDR_RELOAD_B    = 8'h26;
    localparam logic [7:0] ADDR_CONTROL     = 8'h27;

    localparam int unsigned TMR_A = 0;
    localparam int unsigned TMR_B = 1;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        IRQ_NONE    = 2'd0,
        IRQ_RAISED  = 2'd1,
        IRQ_LOWERED = 2'd2
    } t_irq_change;

    typedef struct packed {
        t_op        operation;
        logic [7:0] register_address;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        t_irq_change irq_change;
        logic [1:0]  status_flags;
    } t_result;

endpackage

@@ sv/dit_core.sv @@
// Timer state and single-pass item logic for the dual interval timer.
// Updates both counters, the prescaler and the control registers per item.
// Depends on dit_pkg.
module dit_core
    import dit_pkg::*;
#(
    parameter int unsigned B_PRESCALE = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  t_item   i_item,
    output t_result o_result
);

    localparam logic [PRE_W:0] PRE_LIMIT = (PRE_W+1)'(B_PRESCALE);

    logic [CNT_A_W-1:0] r_cnt_a,    n_cnt_a;
    logic [CNT_B_W-1:0] r_cnt_b,    n_cnt_b;
    logic [PRE_W-1:0]   r_pre_b,    n_pre_b;
    logic [CNT_A_W-1:0] r_reload_a, n_reload_a;
    logic [CNT_B_W-1:0] r_reload_b, n_reload_b;
    logic [1:0]         r_run,      n_run;
    logic [1:0]         r_en_flag,  n_en_flag;
    logic [1:0]         r_mark,     n_mark;
    logic [1:0]         r_status,   n_status;
    logic               raised;
    logic               lowered;

    always_comb begin
        logic [PRE_W:0] pre_inc;
        logic           wrap;
        pre_inc    = {1'b0, r_pre_b} + (PRE_W+1)'(1);
        wrap       = (pre_inc >= PRE_LIMIT);
        n_cnt_a    = r_cnt_a;
        n_cnt_b    = r_cnt_b;
        n_pre_b    = r_pre_b;
        n_reload_a = r_reload_a;
        n_reload_b = r_reload_b;
        n_run      = r_run;
        n_en_flag  = r_en_flag;
        n_mark     = r_mark;
        n_status   = r_status;
        raised     = 1'b0;
        lowered    = 1'b0;
        unique case (i_item.operation)
            OP_TICK: begin
                if (r_run[TMR_A]) begin
                    if (r_cnt_a != A_FULL) begin
                        n_cnt_a = r_cnt_a + CNT_A_W'(1);
                    end else begin
                        if (r_mark[TMR_A]) begin
                            n_mark[TMR_A] = 1'b0;
                        end else if (r_en_flag[TMR_A]) begin
                            n_status[TMR_A] = 1'b1;
                            raised          = 1'b1;
                        end
                        n_cnt_a = r_reload_a;
                    end
                end
                if (wrap) begin
                    n_pre_b = '0;
                    if (r_run[TMR_B]) begin
                        if (r_cnt_b != B_FULL) begin
                            n_cnt_b = r_cnt_b + CNT_B_W'(1);
                        end else begin
                            if (r_mark[TMR_B]) begin
                                n_mark[TMR_B] = 1'b0;
                            end else if (r_en_flag[TMR_B]) begin
                                n_status[TMR_B] = 1'b1;
                                raised          = 1'b1;
                            end
                            n_cnt_b = r_reload_b;
                        end
                    end
                end else begin
                    n_pre_b = pre_inc[PRE_W-1:0];
                    if (r_mark[TMR_B]) begin
                        n_mark[TMR_B] = 1'b0;
                        n_cnt_b       = r_reload_b;
                    end
                end
            end
            OP_WRITE: begin
                unique case (i_item.register_address)
                    ADDR_RELOAD_A_HI: begin
                        n_reload_a = {i_item.write_data, r_reload_a[1:0]};
                    end
                    ADDR_RELOAD_A_LO: begin
                        n_reload_a = {r_reload_a[CNT_A_W-1:2], i_item.write_data[1:0]};
                    end
                    ADDR_RELOAD_B: begin
                        n_reload_b = i_item.write_data;
                    end
                    ADDR_CONTROL: begin
                        if (i_item.write_data[4]) begin
                            n_status[TMR_A] = 1'b0;
                            lowered         = 1'b1;
                        end
                        if (i_item.write_data[5]) begin
                            n_status[TMR_B] = 1'b0;
                            lowered         = 1'b1;
                        end
                        if (i_item.write_data[0] && !r_run[TMR_A]) begin
                            n_cnt_a       = A_FULL;
                            n_mark[TMR_A] = 1'b1;
                        end
                        if (i_item.write_data[1] && !r_run[TMR_B]) begin
                            n_cnt_b       = B_FULL;
                            n_mark[TMR_B] = 1'b1;
                        end
                        n_run     = i_item.write_data[1:0];
                        n_en_flag = i_item.write_data[3:2];
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.status_flags = n_status;
        priority if (raised) begin
            o_result.irq_change = IRQ_RAISED;
        end else if (lowered) begin
            o_result.irq_change = IRQ_LOWERED;
        end else begin
            o_result.irq_change = IRQ_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a    <= A_FULL;
            r_cnt_b    <= B_FULL;
            r_pre_b    <= '0;
            r_reload_a <= '0;
            r_reload_b <= '0;
            r_run      <= '0;
            r_en_flag  <= '0;
            r_mark     <= '0;
            r_status   <= '0;
        end else if (i_en) begin
            r_cnt_a    <= n_cnt_a;
            r_cnt_b    <= n_cnt_b;
            r_pre_b    <= n_pre_b;
            r_reload_a <= n_reload_a;
            r_reload_b <= n_reload_b;
            r_run      <= n_run;
            r_en_flag  <= n_en_flag;
            r_mark     <= n_mark;
            r_status   <= n_status;
        end
    end

`ifndef SYNTHESIS
    a_stopped_a_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_item.operation == OP_TICK && !r_run[TMR_A] |=> $stable(r_cnt_a))
        else $error("timer A counter moved while stopped");

    a_arm_loads_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_item.operation == OP_WRITE && i_item.register_address == ADDR_CONTROL
        && i_item.write_data[0] && !r_run[TMR_A]
        |=> r_cnt_a == A_FULL && r_mark[TMR_A] && r_run[TMR_A])
        else $error("timer A first load not armed");

    a_raise_has_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.irq_change == IRQ_RAISED |-> o_result.status_flags != 2'b00)
        else $error("interrupt raised with no status flag set");

    a_prescale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_pre_b} < PRE_LIMIT)
        else $error("prescaler out of range");
`endif

endmodule

@@ sv/dual_interval_timer_with_status.sv @@
// Top level of the dual interval timer with status flags.
// Registers incoming words, runs them through dit_core and holds the result word.
// Depends on dit_pkg and dit_core.
//
//  Channel   Direction  Signals                     Contents
//  s_        in         s_tvalid s_tready s_tdata   tick or register write
//                       s_tuser
//  m_        out        m_tvalid m_tready m_tdata   status flags and interrupt change
//
// One word is accepted per clock while the result register is not stalled.
// The pace is set by the single pass through dit_core between the input and result
// registers. Reset is synchronous and active low, and clears both timers and all flags.
// A stalled result register holds its word and the input register fills behind it,
// after which s_tready falls until the result word is taken.
module dual_interval_timer_with_status
    import dit_pkg::*;
#(
    parameter int unsigned B_PRESCALE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // register_address[7:0], write_data[15:8]
    input  logic [0:0]  s_tuser,   // operation[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // status_flags[1:0], irq_change[3:2], zero[7:4]
);

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    out_free;
    logic    advance;

    assign out_free = !r_out_valid || m_tready;
    assign advance  = r_in_valid && out_free;
    assign s_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_item.operation        <= t_op'(s_tuser[0]);
            r_in_item.register_address <= s_tdata[7:0];
            r_in_item.write_data       <= s_tdata[15:8];
        end
    end

    dit_core #(
        .B_PRESCALE (B_PRESCALE)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'b0000, r_out.irq_change, r_out.status_flags};

`ifndef SYNTHESIS
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> r_in_valid && r_out_valid)
        else $error("input blocked while a stage is empty");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result word lost after a pass");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule

@@ tb/sv/dual_interval_timer_with_status_test.sv @@
// Self-checking testbench for dual_interval_timer_with_status: stream words of ticks and
// register writes go in, and a built-in timer predictor checks every status result word.
// Depends on dit_pkg and the RTL of the block; needs no files or arguments.
module dual_interval_timer_with_status_test import dit_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned B_PRESCALE_TB  = 16;
    localparam int          CLK_HIGH       = 6;
    localparam int          CLK_LOW        = 6;
    localparam int          RESET_CYCLES   = 10;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          HOLD_OFF       = 300;
    localparam int          RANDOM_WORDS   = 1600;
    localparam int          PRINT_LIMIT    = 200;

    localparam int CTL_RUN_LSB = 0;
    localparam int CTL_EN_LSB  = 2;
    localparam int CTL_CLR_LSB = 4;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_pattern;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // register_address[7:0], write_data[15:8]
    logic [0:0]  s_tuser  = '0;   // operation[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // status_flags[1:0], irq_change[3:2], zero[7:4]

    logic [CNT_A_W-1:0] tmr_cnt_a      = A_FULL;
    logic [CNT_B_W-1:0] tmr_cnt_b      = B_FULL;
    logic [PRE_W-1:0]   tmr_prescale   = '0;
    logic [CNT_A_W-1:0] tmr_reload_a   = '0;
    logic [CNT_B_W-1:0] tmr_reload_b   = '0;
    logic [1:0]         tmr_run        = '0;
    logic [1:0]         tmr_enable     = '0;
    logic [1:0]         tmr_first_load = '0;
    logic [1:0]         tmr_status     = '0;

    t_result     pending_results_q[$];
    int          mismatch_count = 0;
    int          sent_words     = 0;
    int          burst_left     = 0;
    bit          pace_sender    = 1'b0;
    t_rx_pattern rx_mode        = RX_ALWAYS;
    int          hold_left      = 0;
    int          rx_phase       = 0;
    int          idle_cycles    = 0;

    dual_interval_timer_with_status #(
        .B_PRESCALE (B_PRESCALE_TB)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #CLK_LOW i_clk = 1'b1;
        #CLK_HIGH i_clk = 1'b0;
    end

    function automatic t_result timer_step(t_item w);
        logic    raised;
        logic    lowered;
        t_result r;
        raised  = 1'b0;
        lowered = 1'b0;
        if (w.operation == OP_WRITE) begin
            case (w.register_address)
                ADDR_RELOAD_A_HI: tmr_reload_a = {w.write_data, tmr_reload_a[1:0]};
                ADDR_RELOAD_A_LO: tmr_reload_a = {tmr_reload_a[CNT_A_W-1:2], w.write_data[1:0]};
                ADDR_RELOAD_B:    tmr_reload_b = w.write_data;
                ADDR_CONTROL: begin
                    if (w.write_data[CTL_CLR_LSB + TMR_A]) begin
                        tmr_status[TMR_A] = 1'b0;
                        lowered = 1'b1;
                    end
                    if (w.write_data[CTL_CLR_LSB + TMR_B]) begin
                        tmr_status[TMR_B] = 1'b0;
                        lowered = 1'b1;
                    end
                    if (w.write_data[CTL_RUN_LSB + TMR_A] && !tmr_run[TMR_A]) begin
                        tmr_cnt_a = A_FULL;
                        tmr_first_load[TMR_A] = 1'b1;
                    end
                    if (w.write_data[CTL_RUN_LSB + TMR_B] && !tmr_run[TMR_B]) begin
                        tmr_cnt_b = B_FULL;
                        tmr_first_load[TMR_B] = 1'b1;
                    end
                    tmr_run    = w.write_data[CTL_RUN_LSB +: 2];
                    tmr_enable = w.write_data[CTL_EN_LSB +: 2];
                end
                default: ;
            endcase
        end else begin
            if (tmr_run[TMR_A]) begin
                if (tmr_cnt_a != A_FULL) begin
                    tmr_cnt_a = tmr_cnt_a + CNT_A_W'(1);
                end else begin
                    if (tmr_first_load[TMR_A]) begin
                        tmr_first_load[TMR_A] = 1'b0;
                    end else if (tmr_enable[TMR_A]) begin
                        tmr_status[TMR_A] = 1'b1;
                        raised = 1'b1;
                    end
                    tmr_cnt_a = tmr_reload_a;
                end
            end
            if (tmr_prescale == PRE_W'(B_PRESCALE_TB - 1)) begin
                tmr_prescale = '0;
                if (tmr_run[TMR_B]) begin
                    if (tmr_cnt_b != B_FULL) begin
                        tmr_cnt_b = tmr_cnt_b + CNT_B_W'(1);
                    end else begin
                        if (tmr_first_load[TMR_B]) begin
                            tmr_first_load[TMR_B] = 1'b0;
                        end else if (tmr_enable[TMR_B]) begin
                            tmr_status[TMR_B] = 1'b1;
                            raised = 1'b1;
                        end
                        tmr_cnt_b = tmr_reload_b;
                    end
                end
            end else begin
                tmr_prescale = tmr_prescale + PRE_W'(1);
                if (tmr_first_load[TMR_B]) begin
                    tmr_first_load[TMR_B] = 1'b0;
                    tmr_cnt_b = tmr_reload_b;
                end
            end
        end
        r.status_flags = tmr_status;
        r.irq_change   = raised ? IRQ_RAISED : (lowered ? IRQ_LOWERED : IRQ_NONE);
        return r;
    endfunction

    function automatic logic [7:0] control_word(logic [1:0] run, logic [1:0] en,
                                                logic [1:0] clr);
        return {2'($urandom), clr, en, run};
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_word(t_op op, logic [7:0] addr, logic [7:0] data);
        t_item w;
        int    gap;
        if (pace_sender && burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        w.operation        = op;
        w.register_address = addr;
        w.write_data       = data;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {data, addr};
        do @(posedge i_clk); while (!s_tready);
        pending_results_q = {pending_results_q, timer_step(w)};
        if (op == OP_TICK || (addr >= ADDR_RELOAD_A_HI && addr <= ADDR_CONTROL))
            sent_words++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic write_reg(logic [7:0] addr, logic [7:0] data);
        send_word(OP_WRITE, addr, data);
    endtask

    task automatic tick_timers();
        send_word(OP_TICK, 8'($urandom), 8'($urandom));
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        rx_phase++;
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            case (rx_mode)
                RX_RANDOM:   m_tready <= ($urandom_range(0, 9) < 7);
                RX_PERIODIC: m_tready <= ((rx_phase % 7) < 4);
                default:     m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results_q.size() == 0) begin
                report_mismatch("unexpected result word", m_tdata, 0);
            end else begin
                want = pending_results_q.pop_front();
                if (m_tdata[1:0] !== want.status_flags)
                    report_mismatch("status_flags", m_tdata[1:0], want.status_flags);
                if (m_tdata[3:2] !== want.irq_change)
                    report_mismatch("irq_change", m_tdata[3:2], want.irq_change);
                if (m_tdata[7:4] !== 4'd0)
                    report_mismatch("padding bits", m_tdata[7:4], 0);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("dual_interval_timer_with_status_test: FAIL");
            $finish;
        end
    end

    task automatic test_register_map();
        rx_mode = RX_ALWAYS;
        pace_sender = 1'b0;
        tick_timers();
        send_word(OP_TICK, ADDR_CONTROL, 8'hFF);
        write_reg(ADDR_RELOAD_A_HI, 8'hFF);
        write_reg(ADDR_RELOAD_A_LO, 8'hFF);
        write_reg(ADDR_RELOAD_B, 8'hFF);
        write_reg(ADDR_RELOAD_A_HI, 8'h00);
        write_reg(ADDR_RELOAD_A_LO, 8'h00);
        write_reg(ADDR_RELOAD_B, 8'h00);
        write_reg(8'h00, 8'hFF);
        write_reg(8'h23, 8'hFF);
        write_reg(8'h28, 8'hFF);
        write_reg(8'hFF, 8'hFF);
        write_reg(ADDR_CONTROL, control_word(2'b00, 2'b00, 2'b11));
        wait_results_drained();
    endtask

    task automatic test_timer_a_overflow();
        rx_mode = RX_RANDOM;
        write_reg(ADDR_RELOAD_A_HI, 8'hFF);
        write_reg(ADDR_RELOAD_A_LO, 8'h03);
        write_reg(ADDR_CONTROL, control_word(2'b01, 2'b01, 2'b00));
        repeat (4) tick_timers();
        write_reg(ADDR_CONTROL, control_word(2'b01, 2'b01, 2'b01));
        tick_timers();
        write_reg(ADDR_CONTROL, control_word(2'b01, 2'b00, 2'b00));
        repeat (2) tick_timers();
        write_reg(ADDR_CONTROL, control_word(2'b00, 2'b00, 2'b01));
        wait_results_drained();
    endtask

    task automatic test_timer_b_overflow();
        rx_mode = RX_PERIODIC;
        write_reg(ADDR_RELOAD_B, 8'hFF);
        write_reg(ADDR_CONTROL, control_word(2'b10, 2'b00, 2'b00));
        write_reg(ADDR_CONTROL, control_word(2'b00, 2'b00, 2'b00));
        tick_timers();
        write_reg(ADDR_CONTROL, control_word(2'b10, 2'b10, 2'b00));
        repeat (20) tick_timers();
        write_reg(ADDR_CONTROL, control_word(2'b00, 2'b00, 2'b10));
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        rx_mode = RX_ALWAYS;
        pace_sender = 1'b0;
        write_reg(ADDR_RELOAD_A_HI, 8'hFE);
        write_reg(ADDR_CONTROL, control_word(2'b11, 2'b11, 2'b00));
        hold_left = HOLD_OFF;
        repeat (60) begin
            if ($urandom_range(0, 9) == 0)
                write_reg(ADDR_CONTROL, control_word(2'b11, 2'b11, 2'($urandom)));
            else
                tick_timers();
        end
        wait_results_drained();
    endtask

    task automatic run_timer_sequence();
        logic [1:0] run;
        logic [1:0] en;
        int         n;
        if ($urandom_range(0, 1) == 1)
            write_reg(ADDR_RELOAD_A_HI,
                      ($urandom_range(0, 3) != 0) ? 8'($urandom_range(8'hF0, 8'hFF))
                                                  : 8'($urandom));
        write_reg(ADDR_RELOAD_A_LO, 8'($urandom));
        write_reg(ADDR_RELOAD_B,
                  ($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'hF8, 8'hFF))
                                              : 8'($urandom));
        run = 2'($urandom);
        en  = ($urandom_range(0, 3) != 0) ? 2'b11 : 2'($urandom);
        write_reg(ADDR_CONTROL, control_word(run, en, 2'($urandom)));
        n = $urandom_range(10, 150);
        repeat (n) begin
            if ($urandom_range(0, 15) == 0)
                write_reg(ADDR_CONTROL, control_word(run, en, 2'($urandom)));
            else if ($urandom_range(0, 31) == 0)
                send_word(t_op'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
            else
                tick_timers();
        end
        if ($urandom_range(0, 2) == 0)
            write_reg(ADDR_CONTROL, control_word(2'b00, en, 2'($urandom)));
    endtask

    task automatic test_random();
        sent_words = 0;
        while (sent_words < RANDOM_WORDS) begin
            rx_mode = t_rx_pattern'($urandom_range(0, 2));
            pace_sender = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0) begin
                run_timer_sequence();
            end else begin
                repeat ($urandom_range(1, 10))
                    send_word(t_op'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
            end
        end
        wait_results_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_register_map();
        test_timer_a_overflow();
        test_timer_b_overflow();
        test_backpressure();
        test_random();
        if (mismatch_count == 0 && pending_results_q.size() == 0) begin
            $display("dual_interval_timer_with_status_test: PASS");
        end else begin
            $display("dual_interval_timer_with_status_test: FAIL");
        end
        $finish;
    end

endmodule
